/* sv/speck128_block_cipher_top_defines.svh */
// Assertion macros shared by the Speck128 block cipher RTL.
`ifndef SPECK128_BLOCK_CIPHER_TOP_DEFINES_SVH
`define SPECK128_BLOCK_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPECK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SPECK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/speck_pkg.sv */
// Package with the shared types, constants and helper functions of the Speck128 cipher.
`timescale 1ns / 1ps

package speck_pkg;

  localparam int unsigned MAX_ROUNDS = 34;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned RK_AW      = $clog2(MAX_ROUNDS);
  localparam int unsigned CNT_W      = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_KEY_WORDS = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RK_AW-1:0]  rk_addr_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_SIZE   = 3'd0,
    CFG_KEY_WORD_0 = 3'd1,
    CFG_KEY_WORD_1 = 3'd2,
    CFG_KEY_WORD_2 = 3'd3,
    CFG_KEY_WORD_3 = 3'd4
  } cfg_reg_t;

  // Decoded key sizes.
  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_sz_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PRIME,
    ST_ROUND,
    ST_DONE
  } state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic  load_block;
    logic  load_keys;
    logic  expand_step;
    logic  expand_last;
    logic  round_step;
    logic  decrypt;
    cnt_t  step;
  } dp_ctrl_t;

  function automatic word_t rotr64(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t rotl64(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // The unused size code behaves as a 256-bit key.
  function automatic key_sz_t size_code(input logic [1:0] ks);
    key_sz_t sz;
    unique case (ks)
      2'd0:    sz = KEY_128;
      2'd1:    sz = KEY_192;
      default: sz = KEY_256;
    endcase
    return sz;
  endfunction

  function automatic cnt_t round_count(input key_sz_t sz);
    int unsigned t;
    t = 32 + int'(sz);
    if (t > MAX_ROUNDS) begin
      t = MAX_ROUNDS;
    end
    return CNT_W'(t);
  endfunction

endpackage

/* sv/speck_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module speck_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/speck_datapath.sv */
// Speck128 datapath: block and key schedule registers around one shared 64-bit adder.
`timescale 1ns / 1ps

module speck_datapath
  import speck_pkg::*;
(
  input  logic                          clk,
  input  dp_ctrl_t                      ctl,
  input  key_sz_t                       sz,
  input  word_t [NUM_KEY_WORDS-1:0]     key_word,
  input  word_t                         block_hi,
  input  word_t                         block_lo,
  input  word_t                         rk,
  output word_t                         sched_key,
  output word_t                         result_hi,
  output word_t                         result_lo
);

  word_t x, y, k, l0, l1, l2;
  word_t opa, opb, sum;
  logic  sub;
  word_t enc_x, enc_y, dec_x, dec_y, nl_word, k_next;

  // One adder serves the key schedule, the encrypt round and the decrypt round.
  always_comb begin
    dec_y = rotr64(x ^ y, 3);
    if (ctl.expand_step) begin
      opa = k;
      opb = rotr64(l0, 8);
      sub = 1'b0;
    end else if (ctl.decrypt) begin
      opa = x ^ rk;
      opb = dec_y;
      sub = 1'b1;
    end else begin
      opa = rotr64(x, 8);
      opb = y;
      sub = 1'b0;
    end
    sum = sub ? (opa - opb) : (opa + opb);

    enc_x   = sum ^ rk;
    enc_y   = rotl64(y, 3) ^ enc_x;
    dec_x   = rotl64(sum, 8);
    nl_word = sum ^ WORD_W'(ctl.step);
    k_next  = nl_word ^ rotl64(k, 3);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_block) begin
      x <= block_hi;
      y <= block_lo;
    end else if (ctl.round_step) begin
      if (ctl.decrypt) begin
        x <= dec_x;
        y <= dec_y;
      end else begin
        x <= enc_x;
        y <= enc_y;
      end
    end

    if (ctl.load_keys) begin
      unique case (sz)
        KEY_128: begin
          l0 <= key_word[0];
          k  <= key_word[1];
        end
        KEY_192: begin
          l0 <= key_word[1];
          l1 <= key_word[0];
          k  <= key_word[2];
        end
        default: begin
          l0 <= key_word[2];
          l1 <= key_word[1];
          l2 <= key_word[0];
          k  <= key_word[3];
        end
      endcase
    end else if (ctl.expand_step) begin
      // The l-word queue is sz+1 deep; the new word enters at its tail.
      l0 <= (sz == KEY_128) ? nl_word : l1;
      l1 <= (sz == KEY_192) ? nl_word : l2;
      l2 <= nl_word;
      k  <= k_next;
    end
  end

  assign sched_key = k;
  assign result_hi = x;
  assign result_lo = y;

endmodule

/* sv/speck_ctrl.sv */
// Speck128 sequencer: key expansion, key store addressing and round counting.
`timescale 1ns / 1ps

module speck_ctrl
  import speck_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     command,
  input  logic     keys_ready,
  input  cnt_t     rounds,
  output logic     busy,
  output logic     done,
  output rk_addr_t raddr,
  output dp_ctrl_t ctl
);

  state_t state, state_next;
  cnt_t   cnt, cnt_next;
  logic   cmd, cmd_next;
  cnt_t   last;
  cnt_t   cnt_inc;

  // Round key index for a given round: forward for encryption, reversed for decryption.
  function automatic rk_addr_t key_index(input logic dec, input cnt_t c, input cnt_t t);
    cnt_t i;
    i = dec ? (t - CNT_W'(1) - c) : c;
    return i[RK_AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      cmd   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      cmd   <= cmd_next;
    end
  end

  always_comb begin
    last       = rounds - CNT_W'(1);
    cnt_inc    = cnt + CNT_W'(1);
    state_next = state;
    cnt_next   = cnt;
    cmd_next   = cmd;
    raddr      = '0;
    ctl        = '0;
    ctl.decrypt = cmd;
    ctl.step    = cnt;
    busy       = 1'b0;
    done       = 1'b0;

    unique case (state)
      ST_IDLE, ST_DONE: begin
        done = (state == ST_DONE);
        if (start) begin
          cmd_next       = command;
          ctl.load_block = 1'b1;
          cnt_next       = '0;
          if (!keys_ready) begin
            ctl.load_keys = 1'b1;
            state_next    = ST_EXPAND;
          end else begin
            state_next = ST_PRIME;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXPAND: begin
        busy            = 1'b1;
        ctl.expand_step = 1'b1;
        if (cnt == last) begin
          ctl.expand_last = 1'b1;
          cnt_next        = '0;
          state_next      = ST_PRIME;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      ST_PRIME: begin
        busy       = 1'b1;
        raddr      = key_index(cmd, '0, rounds);
        cnt_next   = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        busy           = 1'b1;
        ctl.round_step = 1'b1;
        if (cnt == last) begin
          state_next = ST_DONE;
        end else begin
          raddr    = key_index(cmd, cnt_inc, rounds);
          cnt_next = cnt_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/speck128_block_cipher_top.sv */
// Top level of the Speck128 block cipher with configuration registers and key store.
`timescale 1ns / 1ps
`include "speck128_block_cipher_top_defines.svh"

// Channel        Ports                                   Transaction
// -------------  --------------------------------------  --------------------------------
// block in       start, busy, command, block_hi/_lo      taken when start is high, busy low
// result out     done, result_hi, result_lo              valid for the one cycle done is high
// configuration  cfg_write, cfg_index, cfg_data          written at any edge with cfg_write
//
// A block passes from its accepting edge through a priming state for the registered read of
// the round key store, one round per cycle through the single shared 64-bit adder (32, 33
// or 34 rounds for 128-, 192- or 256-bit keys) and the done state, in which the next block
// may already be started. The first block after reset or after a write to a defined register
// first runs the key schedule, one round key per step, while it fills the store.
// Reset is synchronous and active high; the store needs no clearing. The receiver cannot stall.

module speck128_block_cipher_top
  import speck_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic [63:0]          block_hi,
  input  logic [63:0]          block_lo,
  output logic                 done,
  output logic [63:0]          result_hi,
  output logic [63:0]          result_lo,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // Configuration registers; keys_ready drops on any write to a defined register.
  logic [1:0]                 key_len_sel;
  word_t [NUM_KEY_WORDS-1:0]  key_word;
  logic                       keys_ready;

  key_sz_t  sz;
  cnt_t     rounds;
  rk_addr_t raddr;
  dp_ctrl_t ctl;
  word_t    rk;
  word_t    sched_key;

  assign sz     = size_code(key_len_sel);
  assign rounds = round_count(sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len_sel <= '0;
      key_word    <= '0;
      keys_ready  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_KEY_SIZE: begin
            key_len_sel <= cfg_data[1:0];
            keys_ready  <= 1'b0;
          end
          CFG_KEY_WORD_0: begin
            key_word[0] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_WORD_1: begin
            key_word[1] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_WORD_2: begin
            key_word[2] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_WORD_3: begin
            key_word[3] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end else if (ctl.expand_last) begin
        keys_ready <= 1'b1;
      end
    end
  end

  speck_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .keys_ready (keys_ready),
    .rounds     (rounds),
    .busy       (busy),
    .done       (done),
    .raddr      (raddr),
    .ctl        (ctl)
  );

  // Round key store: written once per schedule step, read one round ahead.
  speck_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROUNDS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ctl.expand_step),
    .waddr (ctl.step[RK_AW-1:0]),
    .wdata (sched_key),
    .raddr (raddr),
    .rdata (rk)
  );

  speck_datapath u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .sz        (sz),
    .key_word  (key_word),
    .block_hi  (block_hi),
    .block_lo  (block_lo),
    .rk        (rk),
    .sched_key (sched_key),
    .result_hi (result_hi),
    .result_lo (result_lo)
  );

  // The result strobe lasts a single cycle.
  `SPECK_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
  // An accepted block makes the block busy in the next cycle.
  `SPECK_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted block did not start work")
  // The key store is written only while the expanded keys are stale.
  `SPECK_ASSERT_NOW(a_expand_stale, ctl.expand_step, !keys_ready, "key expansion with keys ready")
  // Results never appear while the block is still working.
  `SPECK_ASSERT_NOW(a_done_idle, done, !busy, "done raised while busy")

endmodule

/* tb/speck128_block_cipher_top_test.sv */
// Self-checking testbench for the Speck128 block cipher top level.
`timescale 1ns / 1ps

module speck128_block_cipher_top_test;
  import speck_pkg::*;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Commands on the block channel.
  localparam bit OP_ENCRYPT = 1'b0;
  localparam bit OP_DECRYPT = 1'b1;

  localparam int unsigned BASE_ROUNDS = 32;
  localparam int NUM_CFG_REGS = int'(CFG_KEY_WORD_3) + 1;

  localparam int RANDOM_PHASES   = 15;
  localparam int ITEMS_PER_PHASE = 50;

  // Reference cipher plus the queue of ciphertexts or plaintexts still to come out.
  class speck_cipher_checker;
    logic [1:0] key_len_sel;
    word_t      key_words[NUM_KEY_WORDS];
    word_t      round_keys[MAX_ROUNDS];
    bit         keys_valid;
    word_t      expected_hi[$];
    word_t      expected_lo[$];
    int         errors;

    function new();
      key_len_sel = KEY_128;
      foreach (key_words[i]) key_words[i] = '0;
      keys_valid = 1'b0;
      errors     = 0;
    endfunction

    function word_t ror8(word_t v);
      return {v[7:0], v[63:8]};
    endfunction

    function word_t rol8(word_t v);
      return {v[55:0], v[63:56]};
    endfunction

    function word_t ror3(word_t v);
      return {v[2:0], v[63:3]};
    endfunction

    function word_t rol3(word_t v);
      return {v[60:0], v[63:61]};
    endfunction

    function int size_sel();
      return (key_len_sel > KEY_256) ? int'(KEY_256) : int'(key_len_sel);
    endfunction

    function int rounds();
      int t;
      t = BASE_ROUNDS + size_sel();
      return (t > MAX_ROUNDS) ? MAX_ROUNDS : t;
    endfunction

    function void write_reg(cfg_idx_t idx, word_t data);
      case (idx)
        CFG_KEY_SIZE: begin
          key_len_sel = data[1:0];
          keys_valid  = 1'b0;
        end
        CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
          key_words[idx - CFG_KEY_WORD_0] = data;
          keys_valid = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // The last key word in use is k0; the l words run backwards from it.
    function void expand_keys();
      word_t lw[3];
      word_t k;
      word_t nw;
      int    sz;
      int    nl;
      int    t;
      sz = size_sel();
      nl = sz + 1;
      t  = rounds();
      for (int j = 0; j < nl; j++) lw[j] = key_words[(sz - j) % NUM_KEY_WORDS];
      k = key_words[(sz + 1) % NUM_KEY_WORDS];
      round_keys[0] = k;
      for (int i = 0; i + 1 < t; i++) begin
        nw = (k + ror8(lw[0])) ^ word_t'(i);
        for (int j = 0; j + 1 < nl; j++) lw[j] = lw[j + 1];
        lw[nl - 1] = nw;
        k = nw ^ rol3(k);
        round_keys[i + 1] = k;
      end
      keys_valid = 1'b1;
    endfunction

    function void cipher_block(bit cmd, word_t hi, word_t lo,
                               output word_t out_hi, output word_t out_lo);
      word_t x;
      word_t y;
      int    t;
      if (!keys_valid) expand_keys();
      t = rounds();
      x = hi;
      y = lo;
      if (cmd == OP_ENCRYPT) begin
        for (int i = 0; i < t; i++) begin
          x = (ror8(x) + y) ^ round_keys[i];
          y = rol3(y) ^ x;
        end
      end else begin
        for (int i = 0; i < t; i++) begin
          y = ror3(x ^ y);
          x = rol8((x ^ round_keys[t - 1 - i]) - y);
        end
      end
      out_hi = x;
      out_lo = y;
    endfunction

    function void note_block(bit cmd, word_t hi, word_t lo);
      word_t r_hi;
      word_t r_lo;
      cipher_block(cmd, hi, lo, r_hi, r_lo);
      expected_hi.push_back(r_hi);
      expected_lo.push_back(r_lo);
    endfunction

    function void check_block(word_t hi, word_t lo);
      word_t e_hi;
      word_t e_lo;
      if (expected_hi.size() == 0) begin
        $error("result with no block outstanding: result_hi %h result_lo %h", hi, lo);
        errors++;
        return;
      end
      e_hi = expected_hi.pop_front();
      e_lo = expected_lo.pop_front();
      if (hi !== e_hi) begin
        $error("result_hi mismatch: expected %h, actual %h", e_hi, hi);
        errors++;
      end
      if (lo !== e_lo) begin
        $error("result_lo mismatch: expected %h, actual %h", e_lo, lo);
        errors++;
      end
    endfunction

    function int pending();
      return expected_hi.size();
    endfunction

    function void flush_leftover();
      if (expected_hi.size() != 0) begin
        $error("%0d results never came out", expected_hi.size());
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  logic     command = OP_ENCRYPT;
  word_t    block_hi = '0;
  word_t    block_lo = '0;
  logic     done;
  word_t    result_hi;
  word_t    result_lo;
  logic     cfg_write = 1'b0;
  cfg_idx_t cfg_index = CFG_KEY_SIZE;
  word_t    cfg_data = '0;

  speck_cipher_checker sb = new();

  speck128_block_cipher_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .block_hi  (block_hi),
    .block_lo  (block_lo),
    .done      (done),
    .result_hi (result_hi),
    .result_lo (result_lo),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The done strobe lasts one cycle and cannot be held off, so every edge with
  // done high ends exactly one result transaction.
  always @(posedge clk) begin
    if (!rst && done) sb.check_block(result_hi, result_lo);
  end

  // Mostly full-range random words, with the all-zero and all-one corners
  // showing up often enough to matter.
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Indexes past the last key word must be ignored by the block.
  function automatic cfg_idx_t unused_index();
    return cfg_idx_t'($urandom_range((1 << CFG_IDX_W) - 1, CFG_KEY_WORD_3 + 1));
  endfunction

  // Start stays high across back-to-back blocks. The block transaction
  // completes at the first edge where busy was low while start was high.
  task automatic send_block(bit cmd, word_t hi, word_t lo);
    start    <= 1'b1;
    command  <= cmd;
    block_hi <= hi;
    block_lo <= lo;
    do @(posedge clk); while (busy);
    sb.note_block(cmd, hi, lo);
  endtask

  // Register writes go back to back; close_writes drops the enable afterwards.
  task automatic write_reg(cfg_idx_t idx, word_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic close_writes();
    cfg_write <= 1'b0;
  endtask

  // Drops start and waits for every outstanding result. Always waits on the clock
  // before it returns, so that start is never lowered and raised in the same step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Random sender gaps. Mostly short geometric gaps, now and then a long one
  // that can land anywhere in the key expansion or the round loop.
  task automatic pause_sender(int pct);
    if (pct != 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(80, 1)) @(posedge clk);
      end else begin
        do @(posedge clk); while ($urandom_range(99) < pct);
      end
    end
  endtask

  // Writes a random subset of the registers (all of them when asked), and
  // sometimes also a write to an index that does not exist.
  task automatic load_random_key(bit write_all);
    logic [NUM_CFG_REGS-1:0] pick;
    pick = write_all ? '1 : NUM_CFG_REGS'($urandom_range((1 << NUM_CFG_REGS) - 1));
    if (pick == '0) pick[$urandom_range(CFG_KEY_WORD_3)] = 1'b1;
    for (int r = CFG_KEY_SIZE; r <= CFG_KEY_WORD_3; r++) begin
      if (pick[r]) begin
        if (r == CFG_KEY_SIZE) begin
          // Upper data bits are garbage on purpose; only the low two bits count.
          write_reg(CFG_KEY_SIZE, {$urandom, $urandom});
        end else begin
          write_reg(cfg_idx_t'(r), pick_word());
        end
      end
    end
    if ($urandom_range(2) == 0) write_reg(unused_index(), pick_word());
    close_writes();
  endtask

  initial begin
    word_t c_hi;
    word_t c_lo;
    word_t p_hi;
    word_t p_lo;
    int    idle_pcts[3];
    int    pct;

    idle_pcts = '{0, 79, 32};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset key (all-zero words, 128-bit size) with the corner blocks.
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, '1, '0);
    send_block(OP_DECRYPT, '0, '1);
    drain();

    // Spare size code with every data bit set, and an all-ones key.
    write_reg(CFG_KEY_SIZE, '1);
    write_reg(CFG_KEY_WORD_0, '1);
    write_reg(CFG_KEY_WORD_1, '1);
    write_reg(CFG_KEY_WORD_2, '1);
    write_reg(CFG_KEY_WORD_3, '1);
    close_writes();
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '0);
    drain();

    // A write to a missing index after expansion must leave the keys alone.
    write_reg(unused_index(), pick_word());
    close_writes();
    send_block(OP_ENCRYPT, pick_word(), pick_word());
    send_block(OP_DECRYPT, pick_word(), pick_word());
    drain();

    // Published 128-bit key test vector, encrypted and then decrypted.
    write_reg(CFG_KEY_SIZE, KEY_128);
    write_reg(CFG_KEY_WORD_0, 64'h0f0e0d0c0b0a0908);
    write_reg(CFG_KEY_WORD_1, 64'h0706050403020100);
    close_writes();
    send_block(OP_ENCRYPT, 64'h6c61766975716520, 64'h7469206564616d20);
    send_block(OP_DECRYPT, 64'ha65d985179783265, 64'h7860fedf5c570d18);
    drain();

    // 192- and 256-bit keys: encrypt a block, then decrypt the ciphertext.
    write_reg(CFG_KEY_SIZE, KEY_192);
    write_reg(CFG_KEY_WORD_2, pick_word());
    close_writes();
    p_hi = pick_word();
    p_lo = pick_word();
    sb.cipher_block(OP_ENCRYPT, p_hi, p_lo, c_hi, c_lo);
    send_block(OP_ENCRYPT, p_hi, p_lo);
    send_block(OP_DECRYPT, c_hi, c_lo);
    drain();

    write_reg(CFG_KEY_SIZE, KEY_256);
    write_reg(CFG_KEY_WORD_3, '0);
    close_writes();
    p_hi = pick_word();
    p_lo = pick_word();
    sb.cipher_block(OP_ENCRYPT, p_hi, p_lo, c_hi, c_lo);
    send_block(OP_ENCRYPT, p_hi, p_lo);
    send_block(OP_DECRYPT, c_hi, c_lo);

    // Random phases: new key material each phase, idle rate cycling through
    // none, heavy and moderate. Halfway through a phase the sender waits for
    // all results to come back, sometimes followed by a stray register write.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      load_random_key(p == 0);
      pct = idle_pcts[p % 3];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          drain();
          if ($urandom_range(1) == 1) begin
            write_reg(unused_index(), pick_word());
            close_writes();
          end
        end else begin
          pause_sender(pct);
        end
        send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, pick_word(), pick_word());
      end
    end

    start <= 1'b0;
    for (int w = 0; w < 2000 && sb.pending() != 0; w++) @(posedge clk);
    // The longest path is key expansion and then the round loop of a 256-bit key; wait
    // beyond it so that a stray result has room to show up.
    repeat (100) @(posedge clk);
    sb.flush_leftover();

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/speck_pkg.sv
sv/speck_ram.sv
sv/speck_datapath.sv
sv/speck_ctrl.sv
sv/speck128_block_cipher_top.sv
tb/speck128_block_cipher_top_test.sv
